// ----- src/eecr_pkg.sv -----
// Shared types, constants and arithmetic helpers for the ECEF to ENU covariance rotator.
package eecr_pkg;

  localparam int DATA_W        = 48;
  localparam int ANGLE_W       = 32;
  localparam int TRIG_W        = 32;
  localparam int CORDIC_W      = 34;
  localparam int CORDIC_STAGES = 30;
  localparam int NUM_ELEM      = 9;
  localparam int LO_BITS       = DATA_W / 2;
  localparam int LO_W          = LO_BITS + 1 + TRIG_W;
  localparam int HI_W          = DATA_W - LO_BITS + TRIG_W;
  localparam int ACC_W         = DATA_W + TRIG_W + 4;
  localparam int RND_W         = ACC_W - 30;
  localparam int IN_TDATA_W    = 2 * ANGLE_W + NUM_ELEM * DATA_W;
  localparam int OUT_TDATA_W   = NUM_ELEM * DATA_W;
  // CORDIC: 1 setup + 30 micro-rotations + 1 unfold/clamp
  localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
  localparam int ROT_LAT       = CORDIC_LAT + 1;
  localparam int LANE_LAT      = 4;
  localparam int PIPE_LAT      = ROT_LAT + LANE_LAT;

  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = CORDIC_W'(652032874);
  localparam logic signed [TRIG_W-1:0]   ONE_Q30   = TRIG_W'(32'h4000_0000);

  typedef logic signed [TRIG_W-1:0]          trig_t;
  typedef logic signed [CORDIC_W-1:0]        cval_t;
  typedef logic signed [RND_W-1:0]           rnd_t;
  typedef logic [2:0][TRIG_W-1:0]            rrow_t;
  typedef logic [NUM_ELEM-1:0][DATA_W-1:0]   cov_vec_t;

  function automatic cval_t atan_val(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return CORDIC_W'(v);
  endfunction

  function automatic trig_t clamp_q30(input cval_t v);
    trig_t r;
    if (v > CORDIC_W'(ONE_Q30)) begin
      r = ONE_Q30;
    end else if (v < -CORDIC_W'(ONE_Q30)) begin
      r = -ONE_Q30;
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

  // Q2.30 product, round half up by floor shift
  function automatic trig_t mul_q30(input trig_t a, input trig_t b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    p = p + (2*TRIG_W)'(32'h2000_0000);
    return p[TRIG_W+29:30];
  endfunction

  function automatic logic [DATA_W-1:0] sat_data(input rnd_t v);
    logic [DATA_W-1:0] r;
    if ((&v[RND_W-1:DATA_W-1]) || !(|v[RND_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[RND_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- src/ecef_enu_covariance_rotate_core.sv -----
// Top level: ECEF to ENU covariance rotation R*C*R' over nine parallel lanes.
//
//  channel | ports                     | word contents
//  --------+---------------------------+-------------------------------------------
//  input   | in_tvalid/tready/tdata    | latitude, longitude, 9 ECEF cov entries
//  output  | out_tvalid/tready/tdata   | 9 ENU cov entries, saturated
//
// One word per cycle while the sink does not stall; the path runs through the 32-stage
// CORDIC, one rotation-matrix stage and four lane stages, then the output register.
// Reset (rst_n, synchronous) clears the stage valids and the output buffer.
// A stalled sink first fills the skid slot; only then does in_tready drop
// and the whole pipeline hold.
module ecef_enu_covariance_rotate_core import eecr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // latitude_angle, longitude_angle, cov_in_00 .. cov_in_22 (low bit up)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // cov_out_00 .. cov_out_22 (low bit up)
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                en;
  logic [PIPE_LAT-1:0] vld_r;
  trig_t               s_lat, c_lat, s_lon, c_lon;
  cov_vec_t            c_dly_r [ROT_LAT];
  trig_t               r_r [3][3];
  rrow_t               r_row [3];
  rnd_t                acc [NUM_ELEM];

  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  eecr_cordic u_cordic_lat (
    .clk   (clk),
    .en    (en),
    .angle (in_tdata[ANGLE_W-1:0]),
    .sin_q (s_lat),
    .cos_q (c_lat)
  );

  eecr_cordic u_cordic_lon (
    .clk   (clk),
    .en    (en),
    .angle (in_tdata[2*ANGLE_W-1:ANGLE_W]),
    .sin_q (s_lon),
    .cos_q (c_lon)
  );

  // delay the covariance to meet the rotation matrix
  always_ff @(posedge clk) begin
    if (en) begin
      c_dly_r[0] <= in_tdata[IN_TDATA_W-1:2*ANGLE_W];
      for (int d = 1; d < ROT_LAT; d++) begin
        c_dly_r[d] <= c_dly_r[d-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0][0] <= -s_lon;
      r_r[0][1] <= c_lon;
      r_r[0][2] <= '0;
      r_r[1][0] <= -mul_q30(s_lat, c_lon);
      r_r[1][1] <= -mul_q30(s_lat, s_lon);
      r_r[1][2] <= c_lat;
      r_r[2][0] <= mul_q30(c_lat, c_lon);
      r_r[2][1] <= mul_q30(c_lat, s_lon);
      r_r[2][2] <= s_lat;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    assign r_row[i] = {r_r[i][2], r_r[i][1], r_r[i][0]};
  end

  for (genvar i = 0; i < 3; i++) begin : g_li
    for (genvar j = 0; j < 3; j++) begin : g_lj
      eecr_lane u_lane (
        .clk   (clk),
        .en    (en),
        .ri    (r_row[i]),
        .rj    (r_row[j]),
        .cov   (c_dly_r[ROT_LAT-1]),
        .acc_q (acc[3*i+j])
      );
    end
  end

  eecr_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_vld   (vld_r[PIPE_LAT-1]),
    .acc        (acc),
    .pipe_en    (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- src/eecr_cordic.sv -----
// Pipelined rotation-mode CORDIC giving Q2.30 sine and cosine of a binary angle.
module eecr_cordic import eecr_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [ANGLE_W-1:0] angle,
  output trig_t              sin_q,
  output trig_t              cos_q
);

  cval_t      x_r [CORDIC_STAGES+1];
  cval_t      y_r [CORDIC_STAGES+1];
  cval_t      z_r [CORDIC_STAGES+1];
  logic [1:0] q_r [CORDIC_STAGES+1];
  trig_t      sin_r, cos_r;

  logic [31:0] a_full, a_bias, r_res;
  logic [1:0]  quad;

  // fold the angle into one quadrant around zero
  always_comb begin
    a_full = 32'(angle) << (32 - ANGLE_W);
    a_bias = a_full + 32'h2000_0000;
    quad   = a_bias[31:30];
    r_res  = a_full - {quad, 30'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_X0;
      y_r[0] <= '0;
      z_r[0] <= CORDIC_W'(signed'(r_res));
      q_r[0] <= quad;
    end
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    cval_t dx, dy;
    assign dx = x_r[s] >>> s;
    assign dy = y_r[s] >>> s;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1] <= q_r[s];
        if (!z_r[s][CORDIC_W-1]) begin
          x_r[s+1] <= x_r[s] - dy;
          y_r[s+1] <= y_r[s] + dx;
          z_r[s+1] <= z_r[s] - atan_val(s);
        end else begin
          x_r[s+1] <= x_r[s] + dy;
          y_r[s+1] <= y_r[s] - dx;
          z_r[s+1] <= z_r[s] + atan_val(s);
        end
      end
    end
  end

  cval_t xf, yf;
  assign xf = x_r[CORDIC_STAGES];
  assign yf = y_r[CORDIC_STAGES];

  // unfold the quadrant, then clamp
  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[CORDIC_STAGES])
        2'd0: begin
          cos_r <= clamp_q30(xf);
          sin_r <= clamp_q30(yf);
        end
        2'd1: begin
          cos_r <= clamp_q30(-yf);
          sin_r <= clamp_q30(xf);
        end
        2'd2: begin
          cos_r <= clamp_q30(-xf);
          sin_r <= clamp_q30(-yf);
        end
        default: begin
          cos_r <= clamp_q30(yf);
          sin_r <= clamp_q30(-xf);
        end
      endcase
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

// ----- src/eecr_lane.sv -----
// One output lane: weights, split products and registered sum for one ENU entry.
module eecr_lane import eecr_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  rrow_t    ri,
  input  rrow_t    rj,
  input  cov_vec_t cov,
  output rnd_t     acc_q
);

  trig_t                   w_r   [NUM_ELEM];
  cov_vec_t                c_r;
  logic signed [LO_W-1:0]  plo_r [NUM_ELEM];
  logic signed [HI_W-1:0]  phi_r [NUM_ELEM];
  logic signed [ACC_W-1:0] term  [NUM_ELEM];
  logic signed [ACC_W-1:0] grp_r [3];
  logic signed [ACC_W-1:0] total;
  rnd_t                    acc_r;

  for (genvar k = 0; k < 3; k++) begin : g_k
    for (genvar l = 0; l < 3; l++) begin : g_l
      localparam int N = 3 * k + l;
      logic signed [LO_BITS:0]        clo;
      logic signed [DATA_W-LO_BITS-1:0] chi;
      assign clo = signed'({1'b0, c_r[N][LO_BITS-1:0]});
      assign chi = signed'(c_r[N][DATA_W-1:LO_BITS]);
      assign term[N] = (ACC_W'(phi_r[N]) <<< LO_BITS) + ACC_W'(plo_r[N]);

      always_ff @(posedge clk) begin
        if (en) begin
          w_r[N]   <= mul_q30(signed'(ri[k]), signed'(rj[l]));
          plo_r[N] <= clo * w_r[N];
          phi_r[N] <= chi * w_r[N];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= cov;
      for (int g = 0; g < 3; g++) begin
        grp_r[g] <= term[3*g] + term[3*g+1] + term[3*g+2];
      end
      acc_r <= total[ACC_W-1:30];
    end
  end

  assign total = grp_r[0] + grp_r[1] + grp_r[2] + ACC_W'(32'h2000_0000);
  assign acc_q = acc_r;

endmodule

// ----- src/eecr_merge.sv -----
// Saturates the lane sums into one word and holds it in an output register with skid.
module eecr_merge import eecr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pipe_vld,
  input  rnd_t                   acc [NUM_ELEM],
  output logic                   pipe_en,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [OUT_TDATA_W-1:0] sat_word;
  logic [OUT_TDATA_W-1:0] out_r, skid_r;
  logic                   out_v_r, skid_v_r;
  logic                   take;

  always_comb begin
    for (int n = 0; n < NUM_ELEM; n++) begin
      sat_word[n*DATA_W +: DATA_W] = sat_data(acc[n]);
    end
  end

  assign take    = out_v_r && out_tready;
  assign pipe_en = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_r    <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (pipe_vld) begin
      if (!out_v_r || take) begin
        out_r   <= sat_word;
        out_v_r <= 1'b1;
      end else begin
        // park the word while the sink stalls
        skid_r   <= sat_word;
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds a word while output is empty");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_vld && !skid_v_r && out_v_r && !out_tready) |=> skid_v_r)
    else $error("stalled word not parked");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> (out_v_r && !skid_v_r))
    else $error("skid did not drain into output");

endmodule

// ----- sim/ecef_enu_covariance_rotate_checker.sv -----
// Scoreboard for the covariance rotator: predicts each ENU matrix and checks the output words.
module ecef_enu_covariance_rotate_checker import eecr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending,
  output int                     words_in,
  output int                     words_out
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_MAX = (64'sd1 <<< (DATA_W - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  const longint atan_lut [30] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

  logic [OUT_TDATA_W-1:0] enu_queue [$];

  function automatic longint clip_unit(input longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint q30_product(input longint a, input longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  // CORDIC sine/cosine of a binary angle, folded to the near quadrant
  function automatic void angle_trig(input logic [31:0] a, output longint s,
                                     output longint c);
    logic [31:0] quad, resid;
    longint x, y, z, dx, dy;
    quad = ((a + 32'h2000_0000) >> 30) & 32'd3;
    resid = a - (quad << 30);
    z = longint'(signed'(resid));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    case (quad)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = clip_unit(c);
    s = clip_unit(s);
  endfunction

  function automatic logic [OUT_TDATA_W-1:0] rotate_cov(input logic [IN_TDATA_W-1:0] d);
    longint sl, cl, sn, cn;
    longint rot [3][3];
    longint cov [3][3];
    logic signed [127:0] acc, cv, wv;
    logic [OUT_TDATA_W-1:0] res;
    angle_trig(d[31:0], sl, cl);
    angle_trig(d[63:32], sn, cn);
    rot[0][0] = -sn;                 rot[0][1] = cn;                  rot[0][2] = 0;
    rot[1][0] = -q30_product(sl, cn); rot[1][1] = -q30_product(sl, sn); rot[1][2] = cl;
    rot[2][0] = q30_product(cl, cn);  rot[2][1] = q30_product(cl, sn);  rot[2][2] = sl;
    for (int e = 0; e < NUM_ELEM; e++)
      cov[e / 3][e % 3] = longint'(signed'(d[64 + DATA_W * e +: DATA_W]));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          for (int l = 0; l < 3; l++) begin
            cv = cov[k][l];
            wv = q30_product(rot[i][k], rot[j][l]);
            acc += cv * wv;
          end
        end
        acc = (acc + 128'sd536870912) >>> 30;
        if (acc > SAT_MAX) acc = SAT_MAX;
        if (acc < SAT_MIN) acc = SAT_MIN;
        res[DATA_W * (3 * i + j) +: DATA_W] = acc[DATA_W-1:0];
      end
    end
    return res;
  endfunction

  assign pending = enu_queue.size();

  always @(posedge clk) begin
    logic [OUT_TDATA_W-1:0] want;
    if (!rst_n) begin
      fail_count <= 0;
      words_in <= 0;
      words_out <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        enu_queue = {enu_queue, rotate_cov(in_tdata)};
        words_in <= words_in + 1;
      end
      if (out_tvalid && out_tready) begin
        words_out <= words_out + 1;
        if (enu_queue.size() == 0) begin
          $error("output word with no matrix pending: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = enu_queue.pop_front();
          if (want != out_tdata) fail_count <= fail_count + 1;
          for (int e = 0; e < NUM_ELEM; e++)
            if (want[DATA_W * e +: DATA_W] != out_tdata[DATA_W * e +: DATA_W])
              $error("cov_out_%0d%0d: expected %h, got %h", e / 3, e % 3,
                     want[DATA_W * e +: DATA_W], out_tdata[DATA_W * e +: DATA_W]);
        end
      end
    end
  end
endmodule

// ----- sim/ecef_enu_covariance_rotate_core_test.sv -----
// Stimulus, flow control and verdict for the ECEF to ENU covariance rotator.
module ecef_enu_covariance_rotate_core_test;
  import eecr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RANDOM_WORDS = 730;
  localparam int  IDLE_LIMIT   = 3000;
  localparam logic [47:0] C_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] C_MIN = 48'h8000_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int fail_count, pending, words_in, words_out;
  bit gaps_on = 1'b1;
  bit hold_sink = 1'b0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ecef_enu_covariance_rotate_core DUT (.*);
  ecef_enu_covariance_rotate_checker scoreboard (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [47:0] rand_cov();
    case ($urandom_range(0, 5))
      0: return 48'({$urandom, $urandom}) & 48'h0000_00FF_FFFF;
      1: return -(48'({$urandom, $urandom}) & 48'h0000_00FF_FFFF);
      2: return ($urandom_range(0, 1)) ? C_MAX : C_MIN;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_word(input logic [31:0] lat, input logic [31:0] lon,
                           input logic [47:0] cov [9]);
    logic [IN_TDATA_W-1:0] w;
    int g;
    w = {cov[8], cov[7], cov[6], cov[5], cov[4], cov[3], cov[2], cov[1], cov[0], lon, lat};
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  // sink: random back-pressure, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_sink = 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < 2) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        out_tready <= (!gaps_on || $urandom_range(0, 99) < 70);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [47:0] cov [9];
    logic [31:0] edge_angles [8];
    edge_angles = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000,
                    32'hC000_0000, 32'h2000_0000, 32'h1FFF_FFFF, 32'hFFFF_FFFF};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: angle edges and quadrant boundaries, extreme and unit matrices
    for (int i = 0; i < 8; i++) begin
      foreach (cov[e]) cov[e] = (e % 4 == 0) ? 48'h1_0000 : 48'h0;
      send_word(edge_angles[i], edge_angles[7 - i], cov);
    end
    for (int i = 0; i < 8; i++) begin
      foreach (cov[e]) cov[e] = (i % 2) ? C_MIN : C_MAX;
      if (i >= 4) foreach (cov[e]) cov[e] = ((e + i) % 2) ? C_MIN : C_MAX;
      send_word(edge_angles[i], edge_angles[(i + 3) % 8], cov);
    end
    foreach (cov[e]) cov[e] = 48'h0;
    send_word(32'h1234_5678, 32'h9ABC_DEF0, cov);
    foreach (cov[e]) cov[e] = -48'sd1;
    send_word(32'h2000_0000, 32'hE000_0000, cov);

    // let the sender wait until everything is back
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);

    // long sink hold with back-to-back traffic to fill the pipe
    gaps_on = 1'b0;
    hold_sink = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 120) gaps_on = 1'b1;
      if (n == 400) gaps_on = 1'b0;
      if (n == 480) gaps_on = 1'b1;
      foreach (cov[e]) cov[e] = rand_cov();
      send_word($urandom, $urandom, cov);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d matrices in, %0d out: angle wraps, quadrant edges,", words_in,
             words_out);
    $display("saturating extremes, random back-pressure and a long sink hold");
    if (fail_count == 0 && words_in == words_out) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- ecef_enu_covariance_rotate_core.f -----
src/eecr_pkg.sv
src/eecr_cordic.sv
src/eecr_lane.sv
src/eecr_merge.sv
src/ecef_enu_covariance_rotate_core.sv
sim/ecef_enu_covariance_rotate_checker.sv
sim/ecef_enu_covariance_rotate_core_test.sv
